// File: design/cdrs_pkg.sv
// ----------------------------------------------------------------------------
// cdrs_pkg
// Shared types and constants for the rotating card deck.
// ----------------------------------------------------------------------------
package cdrs_pkg;

	localparam int DECK_DEPTH_DEF = 64;
	localparam int CARD_W         = 32;

	typedef logic signed [CARD_W-1:0] card_t;

	typedef enum logic [1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_POP  = 2'd1,
		FUNC_T2B  = 2'd2,
		FUNC_B2T  = 2'd3
	} func_t;

	// move strobe shared by every cell of the chain
	typedef struct packed {
		logic  en;
		func_t func;
	} cell_ctl_t;

endpackage

// File: design/cdrs_cell.sv
// ----------------------------------------------------------------------------
// cdrs_cell
// One deck position. Takes its card from a neighbour, the top card or the
// left feed according to the move broadcast along the chain.
// ----------------------------------------------------------------------------
module cdrs_cell import cdrs_pkg::*; #(
	parameter int CNT_W = 7,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [CNT_W-1:0] count,
	input  card_t            left,
	input  card_t            right,
	input  card_t            top,
	output card_t            card,
	output card_t            bottom_term
);

	card_t card_q;
	logic  not_last;
	logic  is_bottom;

	assign not_last  = CNT_W'(IDX + 1) < count;
	assign is_bottom = count == CNT_W'(IDX + 1);

	// positions beyond the count hold nothing of interest, so they shift freely
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.func)
				FUNC_PUSH: card_q <= left;
				FUNC_POP:  card_q <= right;
				FUNC_T2B:  card_q <= not_last ? right : top;
				FUNC_B2T:  card_q <= left;
				default:   card_q <= card_q;
			endcase
		end
	end

	assign card        = card_q;
	assign bottom_term = is_bottom ? card_q : '0;

endmodule

// File: design/card_deck_rotating_stack_top.sv
// ----------------------------------------------------------------------------
// card_deck_rotating_stack_top
// Bounded deck of signed 32-bit cards held in a chain of cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries func and card_value: push, pop,
// top-to-bottom and bottom-to-top moves. Every input transfer produces one
// result transfer on the output channel (out_valid/out_stall) with ok,
// card_out and cards_held (the count after the move).
// Cell 0 holds the top card; cell n holds the card n places down. Every move
// that succeeds shifts the whole chain by one place in the execute cycle.
// An item passes through a transfer cycle, where the bottom card is picked
// from the chain and registered, and then an execute cycle, where the chain
// shifts and the result register loads. The result is visible the cycle
// after execute; no new item is accepted until the current one executes.
// in_stall is high while an item is being executed. If the receiver stalls
// and the result register is still full, execute waits, holding in_stall.
// Reset empties the deck and drops any pending result; card contents are
// not cleared, only positions holding cards are ever read.
// ----------------------------------------------------------------------------
module card_deck_rotating_stack_top import cdrs_pkg::*; #(
	parameter  int DECK_DEPTH = DECK_DEPTH_DEF,
	localparam int CNT_W      = $clog2(DECK_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	input  card_t            card_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             ok,
	output card_t            card_out,
	output logic [CNT_W-1:0] cards_held
);

	logic             busy_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;
	func_t            func_q;
	card_t            value_q;
	card_t            bottom_s1;
	logic             ok_q;
	card_t            card_out_q;
	logic [CNT_W-1:0] held_q;

	logic             accept_in;
	logic             exec;
	logic             ok_c;
	logic [CNT_W-1:0] count_nxt;
	cell_ctl_t        ctl;
	card_t            left_0;
	card_t            bottom_c;

	card_t cards       [DECK_DEPTH];
	card_t bot_terms   [DECK_DEPTH];
	card_t left_w      [DECK_DEPTH];
	card_t right_w     [DECK_DEPTH];

	assign accept_in = in_valid && !busy_q;
	assign exec      = busy_q && (!out_valid_q || !out_stall);

	always_comb begin
		case (func_q)
			FUNC_PUSH: ok_c = count_q != CNT_W'(DECK_DEPTH);
			FUNC_POP:  ok_c = count_q != '0;
			FUNC_T2B:  ok_c = count_q >= CNT_W'(2);
			FUNC_B2T:  ok_c = count_q >= CNT_W'(2);
			default:   ok_c = 1'b0;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ok_c) begin
			case (func_q)
				FUNC_PUSH: count_nxt = count_q + CNT_W'(1);
				FUNC_POP:  count_nxt = count_q - CNT_W'(1);
				default:   count_nxt = count_q;
			endcase
		end
	end

	assign ctl.en   = exec && ok_c;
	assign ctl.func = func_q;

	// cell 0 is fed the new card on push, the registered bottom card otherwise
	assign left_0 = (func_q == FUNC_PUSH) ? value_q : bottom_s1;

	for (genvar i = 0; i < DECK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_w[i] = left_0;
		end else begin : g_mid
			assign left_w[i] = cards[i-1];
		end
		if (i == DECK_DEPTH - 1) begin : g_last
			assign right_w[i] = cards[0];
		end else begin : g_inner
			assign right_w[i] = cards[i+1];
		end

		cdrs_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.left        (left_w[i]),
			.right       (right_w[i]),
			.top         (cards[0]),
			.card        (cards[i]),
			.bottom_term (bot_terms[i])
		);
	end

	// only the bottom cell contributes a non-zero term
	always_comb begin
		bottom_c = '0;
		for (int k = 0; k < DECK_DEPTH; k++) begin
			bottom_c = bottom_c | bot_terms[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept_in) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			func_q    <= func_t'(func);
			value_q   <= card_value;
			bottom_s1 <= bottom_c;
		end
		if (exec) begin
			ok_q       <= ok_c;
			card_out_q <= (ok_c && func_q == FUNC_POP) ? cards[0] : '0;
			held_q     <= count_nxt;
		end
	end

	assign in_stall   = busy_q;
	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign card_out   = card_out_q;
	assign cards_held = held_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DECK_DEPTH))
		else $error("card count beyond deck depth");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> out_valid_q)
		else $error("executed item left no result");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && ok_c && func_q == FUNC_POP) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not remove one card");

	a_rot_count: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && (func_q == FUNC_T2B || func_q == FUNC_B2T)) |=> $stable(count_q))
		else $error("rotation changed the card count");

	a_held_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> held_q == count_q)
		else $error("reported count differs from deck count");

endmodule
